// File: hw/rtl/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg: shared types and constants of the B-spline curve engine
// Command and status codes, the queued command word and the sequencer states.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_DEGREE_DEF = 7;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_W         = 32;
  localparam int IDX_W          = 7;
  localparam int QDEPTH         = 2;

  // Register indexes on the configuration port.
  localparam logic REG_DEGREE = 1'b0;
  localparam logic REG_EPS    = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD_KNOT  = 2'd0,
    CMD_LOAD_POINT = 2'd1,
    CMD_EVAL       = 2'd2,
    CMD_INSERT     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FEW   = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_KLO, S_KHI, S_SMID, S_SMID1, S_SCHK, S_CPY, S_LVL, S_LVL1,
    S_KA, S_KB, S_W, S_DIV, S_MUL, S_WR, S_SHR, S_SHW, S_KSR, S_KSW,
    S_KINS, S_DONE
  } bst_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic                     idx_bad;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] param;
    logic signed [DATA_W-1:0] coord_x;
    logic signed [DATA_W-1:0] coord_y;
    logic signed [DATA_W-1:0] coord_z;
  } bce_item_t;

endpackage

// File: hw/rtl/bce_if.sv
// ----------------------------------------------------------------------------
// bce_if: command and result channels of the B-spline curve engine
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bce_cmd_if;
  import bce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] param;
  logic signed [DATA_W-1:0] coord_x;
  logic signed [DATA_W-1:0] coord_y;
  logic signed [DATA_W-1:0] coord_z;
  modport source (output valid, command, index, param, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, command, index, param, coord_x, coord_y, coord_z,
                output ready);
endinterface

interface bce_res_if;
  import bce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] point_z;
  logic [1:0]               status;
  modport source (output valid, point_x, point_y, point_z, status, input ready);
  modport sink (input valid, point_x, point_y, point_z, status, output ready);
endinterface

// File: hw/rtl/bspline_curve_engine.sv
// Loads and rejected commands go from idle straight to done, which registers the result.
// Evaluate: span search, then de Boor levels of blends, degree*(degree+1)/2 blends in all,
//   each weight taken from the serial divider unless it is zero or one.
// Insert: shift points above the span, blend degree points, shift knots, write the new knot.
// One command is worked at a time; a two-word queue and the result register decouple I/O.
// Reset clears control state, count and configuration; tables are undefined until written.
// ----------------------------------------------------------------------------
// bspline_curve_engine: B-spline evaluation and knot insertion
// Configuration registers, command intake and the command sequencer.
// ----------------------------------------------------------------------------
module bspline_curve_engine #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = bce_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bce_cmd_if.sink     cmd_i,
  bce_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bce_pkg::*;

  logic [2:0]  degree_q;
  logic [15:0] eps_q;
  bce_item_t   q_item;
  logic        q_valid, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EPS) ? {16'b0, eps_q} : {29'b0, degree_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 3'd3;
      eps_q    <= 16'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DEGREE) degree_q <= pwdata[2:0];
      else eps_q <= pwdata[15:0];
    end
  end

  bce_front #(.MAX_POINTS(MAX_POINTS), .MAX_DEGREE(MAX_DEGREE)) u_front (
    .clk_i, .rst_ni, .cmd_i, .q_item_o(q_item), .q_valid_o(q_valid), .q_pop_i(q_pop)
  );

  bce_back #(.MAX_POINTS(MAX_POINTS), .MAX_DEGREE(MAX_DEGREE), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .degree_i(degree_q), .eps_i(eps_q),
    .q_item_i(q_item), .q_valid_i(q_valid), .q_pop_o(q_pop), .res_o
  );

endmodule

// File: hw/rtl/bce_ram.sv
// ----------------------------------------------------------------------------
// bce_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/bce_front.sv
// ----------------------------------------------------------------------------
// bce_front: command intake
// Accepts command words, flags load indexes beyond the tables and queues them.
// ----------------------------------------------------------------------------
module bce_front #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = bce_pkg::MAX_DEGREE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bce_cmd_if.sink           cmd_i,
  output bce_pkg::bce_item_t q_item_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);
  import bce_pkg::*;

  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int PTR_W      = $clog2(QDEPTH);
  localparam int CNT_W      = $clog2(QDEPTH + 1);

  bce_item_t          ent_q [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  bce_item_t          item_w;
  logic               push_w, pop_w;

  always_comb begin
    item_w.cmd     = cmd_e'(cmd_i.command);
    item_w.index   = cmd_i.index;
    item_w.param   = cmd_i.param;
    item_w.coord_x = cmd_i.coord_x;
    item_w.coord_y = cmd_i.coord_y;
    item_w.coord_z = cmd_i.coord_z;
    item_w.idx_bad = ((item_w.cmd == CMD_LOAD_KNOT) && (cmd_i.index >= KNOT_DEPTH)) ||
                     ((item_w.cmd == CMD_LOAD_POINT) && (cmd_i.index >= MAX_POINTS));
  end

  assign cmd_i.ready = (cnt_q < CNT_W'(QDEPTH));
  assign push_w      = cmd_i.valid && cmd_i.ready;
  assign pop_w       = q_pop_i && (cnt_q != '0);
  assign q_valid_o   = (cnt_q != '0);
  assign q_item_o    = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_w) begin
      ent_q[wr_ptr_q] <= item_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_w) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_w) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push_w) - CNT_W'(pop_w);
    end
  end

endmodule

// File: hw/rtl/bce_back.sv
// ----------------------------------------------------------------------------
// bce_back: command sequencer
// Owns the knot, point and blend tables; runs span search, de Boor blending
// and knot insertion with one serial divider and a three-lane blend unit.
// ----------------------------------------------------------------------------
module bce_back #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF,
  parameter int MAX_DEGREE = bce_pkg::MAX_DEGREE_DEF,
  parameter int FRAC_BITS  = bce_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         degree_i,
  input  logic [15:0]        eps_i,
  input  bce_pkg::bce_item_t q_item_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  bce_res_if.source          res_o
);
  import bce_pkg::*;

  localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
  localparam int IW         = $clog2(KNOT_DEPTH);
  localparam int PAW        = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int SDEPTH     = MAX_DEGREE + 1;
  localparam int SAW        = $clog2(SDEPTH);
  localparam int WW         = FRAC_BITS + 1;
  localparam int PW         = 34 + WW;
  localparam int DCW        = $clog2(FRAC_BITS);
  localparam int VW         = 3 * DATA_W;
  localparam logic [WW-1:0] ONE_W  = WW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

  bst_e                     state_q, state_d;
  bce_item_t                item_q;
  status_e                  st_q, st_w;
  logic [CW-1:0]            count_q;
  logic                     res_valid_q;
  logic [VW-1:0]            res_pt_q;
  status_e                  res_st_q;

  logic signed [DATA_W-1:0] t_q, lo_q, kmid_q, ka_q;
  logic [IW-1:0]            low_q, high_q, k_q, m_q, r_q;
  logic [VW-1:0]            cur_q, prev_q, lerp_q;
  logic [WW-1:0]            w_q;
  logic [33:0]              rem_q, den_q;
  logic [DCW-1:0]           dcnt_q;
  logic signed [PW-1:0]     prod_q [3];

  // Memory ports
  logic                     k_we, p_we, s_we;
  logic [IW-1:0]            k_waddr, k_raddr;
  logic [PAW-1:0]           p_waddr, p_raddr;
  logic [SAW-1:0]           s_waddr, s_raddr;
  logic [DATA_W-1:0]        k_wdata, k_rdata;
  logic [VW-1:0]            p_wdata, p_rdata, s_wdata, s_rdata;

  logic                     start, is_eval, few_w, full_w, go_w;
  logic [IW-1:0]            p_x, mid_w, a_addr, b_addr, first_w, span_k;
  logic                     span_done;
  logic signed [DATA_W-1:0] tc_w;
  logic signed [33:0]       num_w, den_w, eps_x;
  logic                     w_zero, w_one;
  logic [34:0]              rem2_w;
  logic                     ge_w;
  logic signed [32:0]       diff_w [3];
  logic signed [PW-1:0]     prodn_w [3];
  logic signed [PW-1:0]     sh_w [3];
  logic signed [PW:0]       sum_w [3];
  logic [VW-1:0]            lerp_w;

  bce_ram #(.WIDTH(DATA_W), .DEPTH(KNOT_DEPTH)) u_knot (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );
  bce_ram #(.WIDTH(VW), .DEPTH(MAX_POINTS)) u_point (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  bce_ram #(.WIDTH(VW), .DEPTH(SDEPTH)) u_scratch (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // Degree zero acts as one; anything above the supported maximum is clamped.
  always_comb begin
    if (degree_i == '0) begin
      p_x = IW'(1);
    end else if (int'(degree_i) > MAX_DEGREE) begin
      p_x = IW'(MAX_DEGREE);
    end else begin
      p_x = IW'(degree_i);
    end
  end

  assign start   = (state_q == S_IDLE) && q_valid_i && !res_valid_q;
  assign is_eval = (item_q.cmd == CMD_EVAL);
  assign few_w   = IW'(count_q) < (p_x + IW'(1));
  assign full_w  = count_q >= CW'(MAX_POINTS);
  assign go_w    = (q_item_i.cmd inside {CMD_EVAL, CMD_INSERT}) && !few_w &&
                   !((q_item_i.cmd == CMD_INSERT) && full_w);
  assign mid_w   = IW'(((IW + 1)'(low_q) + (IW + 1)'(high_q)) >> 1);
  assign a_addr  = is_eval ? (k_q - p_x + m_q) : m_q;
  assign b_addr  = is_eval ? (k_q + m_q - r_q + IW'(1)) : (m_q + p_x);
  assign first_w = k_q - p_x + IW'(1);

  always_comb begin
    case (q_item_i.cmd)
      CMD_LOAD_KNOT, CMD_LOAD_POINT: st_w = q_item_i.idx_bad ? ST_RANGE : ST_OK;
      default: begin
        if (few_w) begin
          st_w = ST_FEW;
        end else if ((q_item_i.cmd == CMD_INSERT) && full_w) begin
          st_w = ST_RANGE;
        end else begin
          st_w = ST_OK;
        end
      end
    endcase
  end

  // Clamp t to the valid knot range (evaluate only).
  always_comb begin
    tc_w = item_q.param;
    if (is_eval) begin
      if (tc_w > $signed(k_rdata)) tc_w = $signed(k_rdata);
      if (tc_w < lo_q) tc_w = lo_q;
    end
  end

  // Span search exits.
  always_comb begin
    span_done = 1'b0;
    span_k    = mid_w;
    case (state_q)
      S_KHI: begin
        if (tc_w >= $signed(k_rdata)) begin
          span_done = 1'b1;
          span_k    = IW'(count_q) - IW'(1);
        end else if (tc_w <= lo_q) begin
          span_done = 1'b1;
          span_k    = p_x;
        end
      end
      S_SMID: span_done = (high_q - low_q) <= IW'(1);
      S_SCHK: span_done = !((t_q >= $signed(k_rdata)) || (t_q < kmid_q));
      default: ;
    endcase
  end

  // Weight classification and the restoring divider step.
  always_comb begin
    num_w = 34'(t_q) - 34'(ka_q);
    den_w = 34'($signed(k_rdata)) - 34'(ka_q);
    if (is_eval && (den_w < 0)) begin
      num_w = -num_w;
      den_w = -den_w;
    end
    eps_x  = $signed({18'b0, eps_i});
    w_zero = (den_w <= eps_x) || (num_w <= 0);
    w_one  = (num_w >= den_w);
    rem2_w = {rem_q, 1'b0};
    ge_w   = rem2_w >= {1'b0, den_q};
  end

  // Blend lanes: lo + round_half_up((hi - lo) * w), saturated to 32 bits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_w[c]  = 33'($signed(cur_q[c*DATA_W +: DATA_W])) -
                   33'($signed(prev_q[c*DATA_W +: DATA_W]));
      prodn_w[c] = diff_w[c] * $signed({1'b0, w_q});
      sh_w[c]    = (prod_q[c] + $signed(HALF_P)) >>> FRAC_BITS;
      sum_w[c]   = (PW + 1)'($signed(prev_q[c*DATA_W +: DATA_W])) + (PW + 1)'(sh_w[c]);
      if (sum_w[c][PW:DATA_W-1] == '0 || sum_w[c][PW:DATA_W-1] == '1) begin
        lerp_w[c*DATA_W +: DATA_W] = sum_w[c][DATA_W-1:0];
      end else if (sum_w[c][PW]) begin
        lerp_w[c*DATA_W +: DATA_W] = {1'b1, {(DATA_W - 1){1'b0}}};
      end else begin
        lerp_w[c*DATA_W +: DATA_W] = {1'b0, {(DATA_W - 1){1'b1}}};
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = go_w ? S_KLO : S_DONE;
      end
      S_KLO:   state_d = S_KHI;
      S_KHI:   state_d = S_SMID;
      S_SMID:  state_d = S_SMID1;
      S_SMID1: state_d = S_SCHK;
      S_SCHK:  state_d = S_SMID;
      S_CPY:   if (m_q == p_x + IW'(1)) state_d = S_LVL;
      S_LVL:   state_d = S_LVL1;
      S_LVL1:  state_d = S_KA;
      S_KA:    state_d = S_KB;
      S_KB:    state_d = S_W;
      S_W:     state_d = (w_zero || w_one) ? S_MUL : S_DIV;
      S_DIV:   if (dcnt_q == DCW'(FRAC_BITS - 1)) state_d = S_MUL;
      S_MUL:   state_d = S_WR;
      S_WR: begin
        if (is_eval) begin
          if (m_q != r_q) begin
            state_d = S_KA;
          end else begin
            state_d = (r_q == p_x) ? S_DONE : S_LVL;
          end
        end else if (m_q != first_w) begin
          state_d = S_KA;
        end else begin
          state_d = (IW'(KNOT_DEPTH - 1) > k_q + IW'(1)) ? S_KSR : S_KINS;
        end
      end
      S_SHR:   state_d = S_SHW;
      S_SHW:   state_d = (m_q - IW'(1) > k_q) ? S_SHR : S_KA;
      S_KSR:   state_d = S_KSW;
      S_KSW:   state_d = (m_q - IW'(1) > k_q + IW'(1)) ? S_KSR : S_KINS;
      S_KINS:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (span_done) state_d = is_eval ? S_CPY : S_SHR;
  end

  // Memory ports and queue pop
  always_comb begin
    q_pop_o = start;
    k_we    = 1'b0;
    k_waddr = m_q;
    k_wdata = k_rdata;
    k_raddr = mid_w;
    p_we    = 1'b0;
    p_waddr = PAW'(m_q);
    p_wdata = p_rdata;
    p_raddr = PAW'(m_q - IW'(1));
    s_we    = 1'b0;
    s_waddr = SAW'(m_q);
    s_wdata = lerp_w;
    s_raddr = SAW'(m_q - IW'(1));
    case (state_q)
      S_IDLE: begin
        k_raddr = p_x;
        k_waddr = IW'(q_item_i.index);
        k_wdata = q_item_i.param;
        k_we    = start && (q_item_i.cmd == CMD_LOAD_KNOT) && !q_item_i.idx_bad;
        p_waddr = PAW'(q_item_i.index);
        p_wdata = {q_item_i.coord_z, q_item_i.coord_y, q_item_i.coord_x};
        p_we    = start && (q_item_i.cmd == CMD_LOAD_POINT) && !q_item_i.idx_bad;
      end
      S_KLO:   k_raddr = IW'(count_q);
      S_SMID1: k_raddr = mid_w + IW'(1);
      S_CPY: begin
        p_raddr = PAW'(k_q - p_x + m_q);
        s_we    = (m_q != '0);
        s_waddr = SAW'(m_q - IW'(1));
        s_wdata = p_rdata;
      end
      S_LVL:   s_raddr = SAW'(p_x);
      S_KA:    k_raddr = a_addr;
      S_KB:    k_raddr = b_addr;
      S_WR: begin
        s_we    = is_eval;
        p_we    = !is_eval;
        p_wdata = lerp_w;
      end
      S_SHW:   p_we = 1'b1;
      S_KSR:   k_raddr = m_q - IW'(1);
      S_KSW:   k_we = 1'b1;
      S_KINS: begin
        k_we    = 1'b1;
        k_waddr = k_q + IW'(1);
        k_wdata = t_q;
      end
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_q <= q_item_i;
          st_q   <= st_w;
        end
      end
      S_KLO: lo_q <= $signed(k_rdata);
      S_KHI: begin
        t_q    <= tc_w;
        low_q  <= p_x;
        high_q <= IW'(count_q);
      end
      S_SMID1: kmid_q <= $signed(k_rdata);
      S_SCHK: begin
        if (!span_done) begin
          if (t_q < kmid_q) high_q <= mid_w;
          else low_q <= mid_w;
        end
      end
      S_CPY: begin
        m_q <= m_q + IW'(1);
        r_q <= IW'(1);
      end
      S_LVL1: begin
        cur_q <= s_rdata;
        m_q   <= p_x;
      end
      S_KB: begin
        ka_q   <= $signed(k_rdata);
        prev_q <= is_eval ? s_rdata : p_rdata;
      end
      S_W: begin
        w_q    <= w_zero ? '0 : (w_one ? ONE_W : '0);
        rem_q  <= num_w;
        den_q  <= den_w;
        dcnt_q <= '0;
      end
      S_DIV: begin
        w_q    <= {w_q[WW-2:0], ge_w};
        rem_q  <= ge_w ? 34'(rem2_w - {1'b0, den_q}) : 34'(rem2_w);
        dcnt_q <= dcnt_q + DCW'(1);
      end
      S_MUL: begin
        for (int c = 0; c < 3; c++) prod_q[c] <= prodn_w[c];
      end
      S_WR: begin
        lerp_q <= lerp_w;
        cur_q  <= prev_q;
        m_q    <= m_q - IW'(1);
        if (is_eval && (m_q == r_q)) r_q <= r_q + IW'(1);
        if (!is_eval && (m_q == first_w)) m_q <= IW'(KNOT_DEPTH - 1);
      end
      S_SHW: begin
        cur_q <= p_rdata;
        m_q   <= m_q - IW'(1);
      end
      S_KSW: m_q <= m_q - IW'(1);
      default: ;
    endcase
    if (span_done) begin
      k_q <= span_k;
      m_q <= is_eval ? '0 : IW'(count_q);
    end
    if (state_q == S_DONE) begin
      res_pt_q <= (is_eval && (st_q == ST_OK)) ? lerp_q : '0;
      res_st_q <= st_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start && (q_item_i.cmd == CMD_LOAD_POINT) && !q_item_i.idx_bad) begin
        count_q <= CW'(q_item_i.index) + CW'(1);
      end else if (state_q == S_KINS) begin
        count_q <= count_q + CW'(1);
      end
      if (state_q == S_DONE) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.point_x = res_pt_q[DATA_W-1:0];
  assign res_o.point_y = res_pt_q[2*DATA_W-1:DATA_W];
  assign res_o.point_z = res_pt_q[VW-1:2*DATA_W];
  assign res_o.status  = res_st_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_POINTS))
    else $error("point count above table capacity");
  a_span_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CPY || state_q == S_SHR) |-> (k_q >= p_x && k_q < IW'(count_q)))
    else $error("span outside [degree, count-1]");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> !res_valid_q)
    else $error("result register overwritten before it was taken");
  a_weight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (w_q <= ONE_W))
    else $error("blend weight above one");
`endif

endmodule
